// File: rtl/prt_pkg.sv
// Shared types, field widths, operation codes and register indexes for the
// page reference table. Used by every module of the block; depends on nothing.
package prt_pkg;

   // Field widths of the request and response beats.
   localparam int OP_W         = 3;
   localparam int ADDR_W       = 20;
   localparam int PNUM_W       = 17;
   localparam int TS_W         = 32;
   localparam int PAGE_W       = ADDR_W;
   localparam int RSP_TIME_W   = 32;

   // Request beat layout, lowest bits first.
   localparam int REQ_OP_LSB   = 0;
   localparam int REQ_ADDR_LSB = REQ_OP_LSB + OP_W;
   localparam int REQ_PNUM_LSB = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_TS_LSB   = REQ_PNUM_LSB + PNUM_W;
   localparam int REQ_DATA_W   = REQ_TS_LSB + TS_W;

   // Response beat: status, was_valid, reference_bit, last_access_time.
   localparam int RSP_FIELDS_W = 3 + RSP_TIME_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration registers.
   localparam int PAGE_SIZE_W  = 17;
   localparam int FIRST_PAGE_W = 16;
   localparam int MEM_LOC_W    = 21;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = MEM_LOC_W;

   localparam logic [PAGE_SIZE_W-1:0]  PAGE_SIZE_RST  = PAGE_SIZE_W'(1);
   localparam logic [FIRST_PAGE_W-1:0] FIRST_PAGE_RST = '0;
   localparam logic [MEM_LOC_W-1:0]    MEM_LOC_RST    = MEM_LOC_W'(1024);

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_PAGE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEM_LOCS   = 2'd2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ACCESS    = 3'd0;
   localparam logic [OP_W-1:0] OP_SWAP_OUT  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ_TIME = 3'd2;
   localparam logic [OP_W-1:0] OP_TEST_CLR  = 3'd3;
   localparam logic [OP_W-1:0] OP_PREPAGE   = 3'd4;

   // Divider step counter.
   localparam int DIV_CNT_W = $clog2(ADDR_W);

   // Defaults of the top-level parameters.
   localparam int MAX_PAGES_DEF  = 1024;
   localparam int TIME_WIDTH_DEF = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic locate;
      logic lookup;
      logic commit;
      logic clear_step;
   } prt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic clear_last;
      logic out_free;
   } prt_status_type;

endpackage

// File: rtl/prt_divider.sv
// Restoring divider that turns an address into a page number, one quotient
// bit per cycle. Depends on prt_pkg for the address and page size widths.
module prt_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [prt_pkg::ADDR_W-1:0]      dividend,
   input  logic [prt_pkg::PAGE_SIZE_W-1:0] divisor,
   output logic [prt_pkg::ADDR_W-1:0]      quotient,
   output logic                        done
);
   import prt_pkg::*;

   logic                   busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]      quo_ff, quo_in;
   logic [PAGE_SIZE_W-1:0] rem_ff, rem_in;
   logic [PAGE_SIZE_W-1:0] divisor_ff, divisor_in;
   logic [PAGE_SIZE_W:0]   trial;
   logic [PAGE_SIZE_W:0]   diff;
   logic                   fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, quo_ff[ADDR_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign done  = busy_ff && (count_ff == DIV_CNT_W'(ADDR_W - 1));

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[ADDR_W-2:0], fits};
         rem_in   = fits ? diff[PAGE_SIZE_W-1:0] : trial[PAGE_SIZE_W-1:0];
         count_in = count_ff + DIV_CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Operand registers carry no reset.
   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;

endmodule

// File: rtl/prt_datapath.sv
// Datapath of the page reference table: configuration registers, item latch,
// bounds check, entry memory and response register. Depends on prt_pkg and
// prt_divider.
module prt_datapath #(
   parameter int MAX_PAGES  = prt_pkg::MAX_PAGES_DEF,
   parameter int TIME_WIDTH = prt_pkg::TIME_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [prt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [prt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  prt_pkg::prt_cmd_type             cmd,
   output prt_pkg::prt_status_type          status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [prt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import prt_pkg::*;

   localparam int IDX_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int ENTRY_W = TIME_WIDTH + 2;
   localparam int PROD_W  = IDX_W + PAGE_SIZE_W;
   localparam int CMP_W   = (PROD_W > MEM_LOC_W) ? PROD_W : MEM_LOC_W;

   // Configuration registers.
   logic [PAGE_SIZE_W-1:0]  pg_len_ff;
   logic [FIRST_PAGE_W-1:0] first_page_ff;
   logic [MEM_LOC_W-1:0]    mem_locs_ff;

   // Latched item.
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [PNUM_W-1:0] pnum_ff;
   logic [TS_W-1:0]   ts_ff;

   // Bounds check and lookup.
   logic [ADDR_W-1:0] quotient;
   logic [PAGE_W-1:0] page;
   logic [PAGE_W-1:0] offset;
   logic              lo_ok;
   logic              lo_ok_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              in_table;
   logic              op_unused;

   // Entry memory: valid bit, reference bit, timestamp.
   logic [ENTRY_W-1:0] mem [MAX_PAGES];
   logic [ENTRY_W-1:0] rd_ff;
   logic               rd_valid;
   logic               rd_ref;
   logic [TIME_WIDTH-1:0] rd_time;
   logic               mem_we;
   logic               upd_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] upd_data;
   logic [IDX_W-1:0]   clear_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic [RSP_FIELDS_W-1:0] rsp_data_ff;
   logic [RSP_FIELDS_W-1:0] rsp_data_in;
   logic                    res_status;
   logic                    res_was_valid;
   logic                    res_ref;
   logic [RSP_TIME_W-1:0]   res_time;

   // Register writes; the user issues them only while no item is in work.
   always_ff @(posedge clock) begin
      if (reset) begin
         pg_len_ff     <= PAGE_SIZE_RST;
         first_page_ff <= FIRST_PAGE_RST;
         mem_locs_ff   <= MEM_LOC_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_SIZE:  pg_len_ff     <= csr_wdata[PAGE_SIZE_W-1:0];
            CSR_FIRST_PAGE: first_page_ff <= csr_wdata[FIRST_PAGE_W-1:0];
            CSR_MEM_LOCS:   mem_locs_ff   <= csr_wdata[MEM_LOC_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tdata[REQ_OP_LSB +: OP_W];
         addr_ff <= req_tdata[REQ_ADDR_LSB +: ADDR_W];
         pnum_ff <= req_tdata[REQ_PNUM_LSB +: PNUM_W];
         ts_ff   <= req_tdata[REQ_TS_LSB +: TS_W];
      end
   end

   prt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (addr_ff),
      .divisor  (pg_len_ff),
      .quotient (quotient),
      .done     (status.div_done)
   );

   assign op_unused       = op_ff > OP_PREPAGE;
   assign status.need_div = (op_ff == OP_ACCESS) && (pg_len_ff != '0);

   // Lower bound and table depth check on the page number.
   assign page   = (op_ff == OP_ACCESS) ? quotient : PAGE_W'(pnum_ff);
   assign offset = page - PAGE_W'(first_page_ff);
   assign lo_ok  = (page >= PAGE_W'(first_page_ff)) && (offset < PAGE_W'(MAX_PAGES));

   always_ff @(posedge clock) begin
      if (cmd.locate) begin
         lo_ok_ff <= lo_ok;
         idx_ff   <= lo_ok ? offset[IDX_W-1:0] : '0;
      end
   end

   // The index lies inside the table when index * page length < memory size.
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         prod_ff <= PROD_W'(idx_ff) * PROD_W'(pg_len_ff);
      end
   end

   assign in_table = !op_unused && lo_ok_ff && (pg_len_ff != '0) &&
                     (CMP_W'(prod_ff) < CMP_W'(mem_locs_ff));

   assign rd_valid = rd_ff[TIME_WIDTH+1];
   assign rd_ref   = rd_ff[TIME_WIDTH];
   assign rd_time  = rd_ff[TIME_WIDTH-1:0];

   // New entry contents for each operation.
   always_comb begin
      upd_we   = 1'b0;
      upd_data = rd_ff;
      case (op_ff)
         OP_ACCESS: begin
            upd_we   = 1'b1;
            upd_data = {1'b1, 1'b1, TIME_WIDTH'(ts_ff)};
         end
         OP_SWAP_OUT: begin
            upd_we   = 1'b1;
            upd_data = {1'b0, rd_ref, rd_time};
         end
         OP_TEST_CLR: begin
            upd_we   = 1'b1;
            upd_data = {rd_valid, 1'b0, rd_time};
         end
         OP_PREPAGE: begin
            upd_we   = 1'b1;
            upd_data = {1'b1, 1'b1, rd_time};
         end
         default: ;
      endcase
   end

   // The clearing pass shares the single write port with updates.
   assign mem_we    = cmd.clear_step || (cmd.commit && in_table && upd_we);
   assign mem_waddr = cmd.clear_step ? clear_ff : idx_ff;
   assign mem_wdata = cmd.clear_step ? '0 : upd_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.lookup) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_ff <= clear_ff + IDX_W'(1);
      end
   end

   assign status.clear_last = clear_ff == IDX_W'(MAX_PAGES - 1);

   // Result fields; everything but status is zero outside the table.
   assign res_status    = !op_unused && !in_table;
   assign res_was_valid = in_table && (op_ff == OP_ACCESS) && rd_valid;
   assign res_ref       = in_table && (op_ff == OP_TEST_CLR) && rd_ref;
   assign res_time      = (in_table && (op_ff == OP_READ_TIME)) ? RSP_TIME_W'(rd_time) : '0;
   assign rsp_data_in   = {res_time, res_ref, res_was_valid, res_status};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = RSP_DATA_W'(rsp_data_ff);

endmodule

// File: rtl/prt_controller.sv
// Sequencer of the page reference table: clearing pass, divide, bounds check,
// lookup and write-back. Depends on prt_pkg for the command and status types.
module prt_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  prt_pkg::prt_status_type status,
   output prt_pkg::prt_cmd_type    cmd
);
   import prt_pkg::*;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_START   = 3'd2;
   localparam logic [2:0] ST_DIVIDE  = 3'd3;
   localparam logic [2:0] ST_LOCATE  = 3'd4;
   localparam logic [2:0] ST_LOOKUP  = 3'd5;
   localparam logic [2:0] ST_RESPOND = 3'd6;

   logic [2:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_LOCATE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            // Write back and load the response once the output slot is free.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

// File: rtl/page_reference_table_core.sv
// Page reference table: one entry per page holding valid, reference and a
// last-access timestamp, with access, swap-out, read-time, test-and-clear and
// prepage operations. Depends on prt_pkg, prt_controller and prt_datapath.
//
// After reset the block clears its entry memory and takes no request beat
// until that pass is done; register writes are taken throughout. For an
// access beat the address is turned into a page number by a restoring divider
// that yields one quotient bit per cycle over the 20 address bits, followed by
// a bounds check, a multiply that compares the page index against the memory
// size, a registered memory read and the write-back. All other operations, and
// an access while the page length is zero, skip the divider. One item is in
// work at a time; a finished response waits in the output register while the
// next beat is accepted.
module page_reference_table_core #(
   parameter int MAX_PAGES  = prt_pkg::MAX_PAGES_DEF,
   parameter int TIME_WIDTH = prt_pkg::TIME_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration: 0 page length, 1 first page, 2 memory locations.
   input  logic                            csr_we,
   input  logic [prt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Request beat.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operation[2:0], address[22:3], page_number[39:23], timestamp[71:40]
   input  logic [prt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Response beat.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[0], was_valid[1], reference_bit[2], last_access_time[34:3], zeros
   output logic [prt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import prt_pkg::*;

   prt_cmd_type    cmd;
   prt_status_type status;

   prt_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prt_datapath #(
      .MAX_PAGES  (MAX_PAGES),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/prt_checker.sv
// Port-level checks for page_reference_table_core, attached by the bind at the
// end of this file. Depends on prt_pkg for the beat widths.
module prt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [prt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import prt_pkg::*;

   // The clearing pass keeps the request side closed right after reset.
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted during the clearing pass");

   // One item at a time: no second beat in the cycle after an accepted one.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side open directly after an accepted beat");

   // A page outside the table reports nothing but the status flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[RSP_DATA_W-1:1] == '0))
      else $error("fields set on a beat flagged outside the table");

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response beat changed while stalled");

endmodule

bind page_reference_table_core prt_checker u_prt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb_page_reference_table_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_reference_table_core. It drives request
// beats and register writes, and checks every response against a
// behavioural copy of the page table. Depends on prt_pkg and the block's RTL.
module tb_page_reference_table_core;
   import prt_pkg::*;

   localparam int TABLE_DEPTH = MAX_PAGES_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PNUM_MAX    = (1 << PNUM_W) - 1;
   localparam int ADDR_MAX    = (1 << ADDR_W) - 1;
   localparam int SETTINGS_N  = 10;

   // Response fields, status in the lowest bit as on rsp_tdata.
   typedef struct packed {
      logic [RSP_TIME_W-1:0] stamp;
      logic                  ref_bit;
      logic                  was_valid;
      logic                  status;
   } reply_type;

   // Mirror of the page table: register copies, entry stores and the replies
   // still owed by the block, oldest first.
   class page_table_mirror_type;
      logic [PAGE_SIZE_W-1:0]  pg_len;
      logic [FIRST_PAGE_W-1:0] first_page;
      logic [MEM_LOC_W-1:0]    mem_locs;
      logic                    valid_bits [TABLE_DEPTH];
      logic                    ref_bits [TABLE_DEPTH];
      logic [TS_W-1:0]         stamps [TABLE_DEPTH];
      reply_type               owed_replies [$];
      int unsigned             mismatches;

      function new();
         pg_len     = PAGE_SIZE_RST;
         first_page = FIRST_PAGE_RST;
         mem_locs   = MEM_LOC_RST;
         foreach (valid_bits[i]) begin
            valid_bits[i] = 1'b0;
            ref_bits[i]   = 1'b0;
            stamps[i]     = '0;
         end
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_PAGE_SIZE:  pg_len     = value[PAGE_SIZE_W-1:0];
            CSR_FIRST_PAGE: first_page = value[FIRST_PAGE_W-1:0];
            CSR_MEM_LOCS:   mem_locs   = value[MEM_LOC_W-1:0];
            default: ;
         endcase
      endfunction

      // Ceiling of memory size over page length, capped at the table depth.
      function int unsigned page_count();
         longint unsigned n;
         if (pg_len == 0) return 0;
         n = (64'(mem_locs) + 64'(pg_len) - 64'd1) / 64'(pg_len);
         if (n > TABLE_DEPTH) n = TABLE_DEPTH;
         return int'(n);
      endfunction

      // Applies one accepted request to the mirror and queues its reply.
      function void note_request(logic [REQ_DATA_W-1:0] beat);
         logic [OP_W-1:0]   op;
         logic [ADDR_W-1:0] addr;
         logic [PNUM_W-1:0] pnum;
         logic [TS_W-1:0]   ts;
         longint unsigned   page;
         int unsigned       idx;
         reply_type         rep;
         op   = beat[REQ_OP_LSB +: OP_W];
         addr = beat[REQ_ADDR_LSB +: ADDR_W];
         pnum = beat[REQ_PNUM_LSB +: PNUM_W];
         ts   = beat[REQ_TS_LSB +: TS_W];
         rep  = '0;
         // Unused operation codes leave everything alone and return zeros.
         if (op <= OP_PREPAGE) begin
            if (op == OP_ACCESS)
               page = (pg_len == 0) ? 64'd0 : 64'(addr) / 64'(pg_len);
            else
               page = 64'(pnum);
            if (pg_len == 0 || page < 64'(first_page) ||
                page - 64'(first_page) >= 64'(page_count())) begin
               rep.status = 1'b1;
            end else begin
               idx = int'(page - 64'(first_page));
               case (op)
                  OP_ACCESS: begin
                     rep.was_valid   = valid_bits[idx];
                     valid_bits[idx] = 1'b1;
                     ref_bits[idx]   = 1'b1;
                     stamps[idx]     = ts;
                  end
                  OP_SWAP_OUT:  valid_bits[idx] = 1'b0;
                  OP_READ_TIME: rep.stamp = stamps[idx];
                  OP_TEST_CLR: begin
                     rep.ref_bit   = ref_bits[idx];
                     ref_bits[idx] = 1'b0;
                  end
                  default: begin
                     valid_bits[idx] = 1'b1;
                     ref_bits[idx]   = 1'b1;
                  end
               endcase
            end
         end
         owed_replies = {owed_replies, rep};
      endfunction

      // Compares one accepted response with the oldest owed reply.
      function void check_reply(logic [RSP_DATA_W-1:0] beat);
         reply_type seen;
         reply_type want;
         seen = beat[RSP_FIELDS_W-1:0];
         if (owed_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with none owed: %h", $realtime, beat);
            return;
         end
         want = owed_replies.pop_front();
         if (seen.status !== want.status || seen.was_valid !== want.was_valid ||
             seen.ref_bit !== want.ref_bit || seen.stamp !== want.stamp) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: bad reply: status %b/%b was_valid %b/%b ref %b/%b",
                         " time %h/%h (want/got)"},
                        $realtime, want.status, seen.status, want.was_valid,
                        seen.was_valid, want.ref_bit, seen.ref_bit, want.stamp,
                        seen.stamp);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // operation[2:0], address[22:3], page_number[39:23], timestamp[71:40]
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status[0], was_valid[1], reference_bit[2], last_access_time[34:3], zeros
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   page_table_mirror_type mirror;
   int unsigned      cycles = 0;
   logic             steady = 1'b0;
   int unsigned      steady_left = 0;
   int unsigned      stall_left = 0;
   int unsigned      stall_len;

   page_reference_table_core DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Alternates stretches where both sides run flat out with idling ones.
   always @(posedge clock) begin
      if (steady_left == 0) begin
         steady      <= ($urandom_range(0, 3) == 0);
         steady_left <= $urandom_range(200, 800);
      end else begin
         steady_left <= steady_left - 1;
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
         stall_len = pick_gap();
         rsp_tready <= (stall_len == 0);
         if (stall_len != 0) stall_left <= stall_len - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Beat monitors on both channels, plus the run-time limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) mirror.check_reply(rsp_tdata);
         if (req_tvalid && req_tready) mirror.note_request(req_tdata);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] make_beat(logic [OP_W-1:0] op,
                                                      int unsigned addr,
                                                      int unsigned pnum,
                                                      logic [TS_W-1:0] ts);
      logic [REQ_DATA_W-1:0] beat;
      beat = '0;
      beat[REQ_OP_LSB +: OP_W]     = op;
      beat[REQ_ADDR_LSB +: ADDR_W] = ADDR_W'(addr);
      beat[REQ_PNUM_LSB +: PNUM_W] = PNUM_W'(pnum);
      beat[REQ_TS_LSB +: TS_W]     = ts;
      return beat;
   endfunction

   // Presents one request beat and returns at the edge that accepts it.
   task automatic send_request(input logic [REQ_DATA_W-1:0] beat);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Lets the block drain until every owed reply has been seen; the first
   // edge lets the monitor note the beat accepted last.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.owed_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      mirror.write_register(index, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic apply_setting(input int unsigned ps, input int unsigned fp,
                                input int unsigned mem);
      write_csr(CSR_PAGE_SIZE, ps);
      write_csr(CSR_FIRST_PAGE, fp);
      write_csr(CSR_MEM_LOCS, mem);
      csr_we <= 1'b0;
   endtask

   function automatic logic [OP_W-1:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return OP_W'(OP_PREPAGE + $urandom_range(1, 3));
      if (r < 40) return OP_ACCESS;
      if (r < 55) return OP_SWAP_OUT;
      if (r < 70) return OP_READ_TIME;
      if (r < 85) return OP_TEST_CLR;
      return OP_PREPAGE;
   endfunction

   // Picks a page around the table: mostly a few low entries so that state is
   // reused, otherwise anywhere inside, just past the end or just below it.
   function automatic longint pick_page();
      int unsigned cnt;
      int unsigned r;
      longint      idx;
      cnt = mirror.page_count();
      r   = $urandom_range(0, 99);
      if (cnt == 0)
         idx = $urandom_range(0, 3);
      else if (r < 45)
         idx = $urandom_range(0, (cnt < 12 ? cnt : 12) - 1);
      else if (r < 80)
         idx = $urandom_range(0, cnt - 1);
      else if (r < 90)
         idx = cnt + $urandom_range(0, 2);
      else
         idx = -1 - longint'($urandom_range(0, 1));
      return longint'(mirror.first_page) + idx;
   endfunction

   task automatic run_random(input int unsigned n);
      logic [OP_W-1:0] op;
      longint          page;
      longint          base;
      int unsigned     addr;
      int unsigned     pnum;
      for (int k = 0; k < n; k++) begin
         op   = pick_op();
         page = pick_page();
         addr = $urandom_range(0, ADDR_MAX);
         pnum = $urandom_range(0, PNUM_MAX);
         // A few beats stay fully random; the rest aim at the table.
         if ($urandom_range(0, 99) >= 15) begin
            if (page >= 0 && page <= PNUM_MAX) pnum = int'(page);
            base = page * longint'(mirror.pg_len);
            if (mirror.pg_len != 0 && page >= 0 && base <= ADDR_MAX) begin
               base = base + $urandom_range(0, mirror.pg_len - 1);
               addr = (base > ADDR_MAX) ? ADDR_MAX : int'(base);
            end
         end
         send_request(make_beat(op, addr, pnum, $urandom()));
      end
   endtask

   int unsigned ps_list  [SETTINGS_N] = '{1, 65536, 0, 7, 1, 3, 131071, 1000, 1, 1};
   int unsigned fp_list  [SETTINGS_N] = '{0, 65535, 10, 3, 0, 40000, 2, 500, 0, 0};
   int unsigned mem_list [SETTINGS_N] = '{1, 1048576, 1024, 0, 1048576, 1000,
                                          1048576, 777777, 1, 1024};

   initial begin
      mirror = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset register values.
      send_request(make_beat(OP_ACCESS, 5, 0, 32'hFFFF_FFFF));
      send_request(make_beat(OP_ACCESS, 5, 0, 32'h1234_5678));
      send_request(make_beat(OP_READ_TIME, 0, 5, 32'h0));
      send_request(make_beat(OP_TEST_CLR, 0, 5, 32'h0));
      send_request(make_beat(OP_TEST_CLR, 0, 5, 32'h0));
      send_request(make_beat(OP_SWAP_OUT, 0, 5, 32'h0));
      send_request(make_beat(OP_ACCESS, 5, 0, 32'h0));
      send_request(make_beat(OP_READ_TIME, 0, 5, 32'hFFFF_FFFF));
      send_request(make_beat(OP_PREPAGE, 0, 1023, 32'h0));
      send_request(make_beat(OP_TEST_CLR, 0, 1023, 32'h0));
      send_request(make_beat(OP_ACCESS, 1023, 0, 32'hA5A5_A5A5));
      send_request(make_beat(OP_READ_TIME, ADDR_MAX, 1023, 32'h0));
      send_request(make_beat(OP_ACCESS, 1024, 0, 32'h5A5A_5A5A));
      send_request(make_beat(OP_ACCESS, ADDR_MAX, PNUM_MAX, 32'hFFFF_FFFF));
      // Entries never touched read back as cleared, reference bit included.
      send_request(make_beat(OP_READ_TIME, 0, 0, 32'h0));
      send_request(make_beat(OP_TEST_CLR, 0, 0, 32'h0));
      send_request(make_beat(OP_PREPAGE, 0, 66559, 32'h0));
      send_request(make_beat(OP_SWAP_OUT, 0, PNUM_MAX, 32'h0));
      send_request(make_beat(OP_W'(OP_PREPAGE + 1), ADDR_MAX, PNUM_MAX, 32'hFFFF_FFFF));
      send_request(make_beat(OP_W'(OP_PREPAGE + 2), 5, 5, 32'h0));
      send_request(make_beat(OP_W'(OP_PREPAGE + 3), 0, 1023, 32'h1));
      send_request(make_beat(OP_TEST_CLR, 0, 1023, 32'h0));
      drain();

      // Register settings: one page, highest first page, zero page length, zero
      // memory, capped table, odd sizes, a random one and the reset values.
      ps_list[8]  = $urandom_range(1, 4096);
      fp_list[8]  = $urandom_range(0, 1000);
      mem_list[8] = $urandom_range(1, 1048576);
      for (int s = 0; s < SETTINGS_N; s++) begin
         apply_setting(ps_list[s], fp_list[s], mem_list[s]);
         run_random((mirror.page_count() == 0) ? 60 : 200);
         drain();
      end

      repeat (40) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.owed_replies.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
rtl/prt_pkg.sv
rtl/prt_divider.sv
rtl/prt_datapath.sv
rtl/prt_controller.sv
rtl/page_reference_table_core.sv
rtl/prt_checker.sv
test/tb_page_reference_table_core.sv
